/* design/touch_gesture_to_hid_mouse_macros.svh */
// Assertion macros shared by the touch-to-mouse blocks.
`ifndef TOUCH_GESTURE_TO_HID_MOUSE_MACROS_SVH
`define TOUCH_GESTURE_TO_HID_MOUSE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define TGM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define TGM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/tgm_pkg.sv */
// Shared types, codes and constants of the touch-to-mouse converter.
package tgm_pkg;

    localparam int COORD_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QUEUE_LIMIT  = 1024;
    localparam int REPORT_LIMIT = 127;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    // Event kinds
    localparam logic [1:0] FUNC_PRESS   = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_DRAG    = 2'd2;
    localparam logic [1:0] FUNC_TICK    = 2'd3;

    // Acceleration levels
    localparam logic [1:0] GAIN_UNIT   = 2'd1;
    localparam logic [1:0] GAIN_MEDIUM = 2'd2;
    localparam logic [1:0] GAIN_FAST   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POINTER_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MIN_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MOVE_LIM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_ZONE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_SPEED    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_SPEED  = 3'd7;

    typedef struct packed {
        logic [3:0]  pointer_gain;
        logic [15:0] hold_delay;
        logic [15:0] tap_min_len;
        logic [15:0] tap_max_len;
        logic [15:0] tap_move_limit;
        logic [9:0]  scroll_zone_start;
        logic [10:0] fast_speed_limit;
        logic [10:0] medium_speed_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        pointer_gain:       4'd1,
        hold_delay:         16'd30,
        tap_min_len:        16'd3,
        tap_max_len:        16'd18,
        tap_move_limit:     16'd4,
        scroll_zone_start:  10'd210,
        fast_speed_limit:   11'd20,
        medium_speed_limit: 11'd10
    };

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic do_press;
        logic do_release;
        logic do_dist;
        logic do_mul;
        logic do_acc;
        logic do_count;
        logic do_hold;
        logic do_send;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       is_pressed;
        logic       pending;
        logic       host_ready;
        logic       out_free;
    } t_dp_sts;

endpackage

/* design/tgm_evt_if.sv */
// Touch event channel.
interface tgm_evt_if import tgm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [COORD_W-1:0] touch_x;
    logic [COORD_W-1:0] touch_y;
    logic [COORD_W-1:0] prev_x;
    logic [COORD_W-1:0] prev_y;
    logic               host_ready;

    modport source (output valid, func, touch_x, touch_y, prev_x, prev_y, host_ready,
                    input ready);
    modport sink   (input valid, func, touch_x, touch_y, prev_x, prev_y, host_ready,
                    output ready);
endinterface

/* design/tgm_rpt_if.sv */
// Mouse report channel.
interface tgm_rpt_if import tgm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              left_button;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic signed [7:0] wheel;

    modport source (output valid, left_button, move_x, move_y, wheel, input ready);
    modport sink   (input valid, left_button, move_x, move_y, wheel, output ready);
endinterface

/* design/tgm_cfg_regs.sv */
// Configuration register bank.
module tgm_cfg_regs import tgm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POINTER_GAIN:  r_cfg.pointer_gain       <= i_cfg_data[3:0];
                CFG_HOLD_DELAY:    r_cfg.hold_delay         <= i_cfg_data;
                CFG_TAP_MIN_LEN:   r_cfg.tap_min_len        <= i_cfg_data;
                CFG_TAP_MAX_LEN:   r_cfg.tap_max_len        <= i_cfg_data;
                CFG_TAP_MOVE_LIM:  r_cfg.tap_move_limit     <= i_cfg_data;
                CFG_SCROLL_ZONE:   r_cfg.scroll_zone_start  <= i_cfg_data[9:0];
                CFG_FAST_SPEED:    r_cfg.fast_speed_limit   <= i_cfg_data[10:0];
                CFG_MEDIUM_SPEED:  r_cfg.medium_speed_limit <= i_cfg_data[10:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/tgm_dp.sv */
// Gesture datapath: event registers, gesture state, movement queues, report register.
`include "touch_gesture_to_hid_mouse_macros.svh"
module tgm_dp import tgm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [1:0]         i_func,
    input  logic [COORD_W-1:0] i_touch_x,
    input  logic [COORD_W-1:0] i_touch_y,
    input  logic [COORD_W-1:0] i_prev_x,
    input  logic [COORD_W-1:0] i_prev_y,
    input  logic               i_host_ready,
    input  logic               i_rpt_ready,
    output logic               o_rpt_valid,
    output logic               o_left_button,
    output logic signed [7:0]  o_move_x,
    output logic signed [7:0]  o_move_y,
    output logic signed [7:0]  o_wheel
);

    localparam logic signed [18:0] QSUM_HI = 19'(QUEUE_LIMIT);
    localparam logic signed [18:0] QSUM_LO = 19'(-QUEUE_LIMIT);
    localparam logic signed [11:0] Q_HI    = 12'(QUEUE_LIMIT);
    localparam logic signed [11:0] Q_LO    = 12'(-QUEUE_LIMIT);
    localparam logic signed [11:0] RPT_HI  = 12'(REPORT_LIMIT);
    localparam logic signed [11:0] RPT_LO  = 12'(-REPORT_LIMIT);

    function automatic logic signed [11:0] clamp_q(input logic signed [18:0] v);
        if (v > QSUM_HI) return Q_HI;
        else if (v < QSUM_LO) return Q_LO;
        else return v[11:0];
    endfunction

    function automatic logic signed [7:0] clamp_rpt(input logic signed [11:0] v);
        if (v > RPT_HI) return RPT_HI[7:0];
        else if (v < RPT_LO) return RPT_LO[7:0];
        else return v[7:0];
    endfunction

    // Latched event
    logic [1:0]         r_func;
    logic [COORD_W-1:0] r_tx, r_ty, r_px, r_py;
    logic               r_host_ready;

    // Gesture state
    logic               r_is_pressed, r_scroll_mode, r_hold_active, r_click_due;
    logic               r_wanted, r_sent;
    logic [15:0]        r_tick_cnt, r_moved;
    logic signed [11:0] r_qx, r_qy;
    logic signed [7:0]  r_qw;

    // Drag pipeline
    logic signed [10:0] r_dx, r_dy;
    logic [5:0]         r_gain;
    logic signed [17:0] r_prod_x, r_prod_y;

    // Report register
    logic               r_out_valid, r_out_btn;
    logic signed [7:0]  r_out_x, r_out_y, r_out_w;

    logic signed [10:0] dx, dy, adx, ady;
    logic [10:0]        drag_len;
    logic [16:0]        moved_sum;
    logic [15:0]        n_moved;
    logic [1:0]         gain_sel;
    logic [5:0]         gain;
    logic signed [17:0] dx_ext, dy_ext, gain_ext;
    logic signed [18:0] sum_x, sum_y;
    logic signed [11:0] sum_w;
    logic signed [7:0]  rx, ry, rw;
    logic               still, tap_ok, hold_ok, pending, out_free;

    assign dx        = $signed({1'b0, r_tx}) - $signed({1'b0, r_px});
    assign dy        = $signed({1'b0, r_ty}) - $signed({1'b0, r_py});
    assign adx       = dx[10] ? -dx : dx;
    assign ady       = dy[10] ? -dy : dy;
    assign drag_len  = {1'b0, adx[9:0]} + {1'b0, ady[9:0]};
    assign moved_sum = {1'b0, r_moved} + {6'b0, drag_len};
    assign n_moved   = moved_sum[16] ? SAT16 : moved_sum[15:0];

    always_comb begin
        if (drag_len > i_cfg.fast_speed_limit) gain_sel = GAIN_FAST;
        else if (drag_len > i_cfg.medium_speed_limit) gain_sel = GAIN_MEDIUM;
        else gain_sel = GAIN_UNIT;
    end
    assign gain = {4'b0, gain_sel} * {2'b0, i_cfg.pointer_gain};

    assign dx_ext   = {{7{r_dx[10]}}, r_dx};
    assign dy_ext   = {{7{r_dy[10]}}, r_dy};
    assign gain_ext = $signed({12'b0, r_gain});

    assign sum_x = {{7{r_qx[11]}}, r_qx} + {r_prod_x[17], r_prod_x};
    assign sum_y = {{7{r_qy[11]}}, r_qy} + {r_prod_y[17], r_prod_y};
    assign sum_w = {{4{r_qw[7]}}, r_qw} + {r_dy[10], r_dy};

    assign rx = clamp_rpt(r_qx);
    assign ry = clamp_rpt(r_qy);
    assign rw = clamp_rpt({{4{r_qw[7]}}, r_qw});

    assign still   = r_moved <= i_cfg.tap_move_limit;
    assign tap_ok  = !r_scroll_mode && (r_tick_cnt >= i_cfg.tap_min_len)
                     && (r_tick_cnt <= i_cfg.tap_max_len) && still;
    assign hold_ok = r_is_pressed && !r_scroll_mode && !r_hold_active
                     && (r_tick_cnt >= i_cfg.hold_delay) && still;
    assign pending  = (r_qx != '0) || (r_qy != '0) || (r_qw != '0) || (r_wanted != r_sent);
    assign out_free = !r_out_valid || i_rpt_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_pressed  <= 1'b0;
            r_scroll_mode <= 1'b0;
            r_hold_active <= 1'b0;
            r_click_due   <= 1'b0;
            r_wanted      <= 1'b0;
            r_sent        <= 1'b0;
            r_tick_cnt    <= '0;
            r_moved       <= '0;
            r_qx          <= '0;
            r_qy          <= '0;
            r_qw          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.do_press) begin
                r_is_pressed  <= 1'b1;
                r_hold_active <= 1'b0;
                r_tick_cnt    <= '0;
                r_moved       <= '0;
                r_scroll_mode <= r_tx >= i_cfg.scroll_zone_start;
            end
            if (i_cmd.do_release) begin
                r_is_pressed <= 1'b0;
                if (r_hold_active) begin
                    r_wanted      <= 1'b0;
                    r_hold_active <= 1'b0;
                end else if (tap_ok) begin
                    r_wanted    <= 1'b1;
                    r_click_due <= 1'b1;
                end
            end
            if (i_cmd.do_dist) begin
                r_moved <= n_moved;
            end
            if (i_cmd.do_acc) begin
                if (r_scroll_mode) begin
                    r_qw <= clamp_rpt(sum_w);
                end else begin
                    r_qx <= clamp_q(sum_x);
                    r_qy <= clamp_q(sum_y);
                end
            end
            if (i_cmd.do_count && r_is_pressed && (r_tick_cnt != SAT16)) begin
                r_tick_cnt <= r_tick_cnt + 16'd1;
            end
            if (i_cmd.do_hold && hold_ok) begin
                r_wanted      <= 1'b1;
                r_hold_active <= 1'b1;
            end
            if (i_cmd.do_send) begin
                r_qx   <= r_qx - {{4{rx[7]}}, rx};
                r_qy   <= r_qy - {{4{ry[7]}}, ry};
                r_qw   <= r_qw - rw;
                r_sent <= r_wanted;
                if (r_click_due && r_wanted) begin
                    r_wanted    <= 1'b0;
                    r_click_due <= 1'b0;
                end
                r_out_valid <= 1'b1;
            end else if (i_rpt_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func       <= i_func;
            r_tx         <= i_touch_x;
            r_ty         <= i_touch_y;
            r_px         <= i_prev_x;
            r_py         <= i_prev_y;
            r_host_ready <= i_host_ready;
        end
        if (i_cmd.do_dist) begin
            r_dx   <= dx;
            r_dy   <= dy;
            r_gain <= gain;
        end
        if (i_cmd.do_mul) begin
            r_prod_x <= dx_ext * gain_ext;
            r_prod_y <= dy_ext * gain_ext;
        end
        if (i_cmd.do_send) begin
            r_out_btn <= r_wanted;
            r_out_x   <= rx;
            r_out_y   <= ry;
            r_out_w   <= rw;
        end
    end

    assign o_sts = '{
        func:       r_func,
        is_pressed: r_is_pressed,
        pending:    pending,
        host_ready: r_host_ready,
        out_free:   out_free
    };

    assign o_rpt_valid   = r_out_valid;
    assign o_left_button = r_out_btn;
    assign o_move_x      = r_out_x;
    assign o_move_y      = r_out_y;
    assign o_wheel       = r_out_w;

    `TGM_ASSERT_NOW(a_qx_bounded, 1'b1, r_qx <= Q_HI && r_qx >= Q_LO, "x queue out of range")
    `TGM_ASSERT_NOW(a_qy_bounded, 1'b1, r_qy <= Q_HI && r_qy >= Q_LO, "y queue out of range")
    `TGM_ASSERT_NEXT(a_sent_tracks, i_cmd.do_send, r_sent == r_out_btn, "sent button mismatch")

endmodule

/* design/tgm_ctrl.sv */
// Event sequencer driving the gesture datapath.
`include "touch_gesture_to_hid_mouse_macros.svh"
module tgm_ctrl import tgm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_evt_valid,
    output logic    o_evt_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_EXEC      = 3'd1;
    localparam logic [2:0] S_DRAG_MUL  = 3'd2;
    localparam logic [2:0] S_DRAG_ACC  = 3'd3;
    localparam logic [2:0] S_TICK_HOLD = 3'd4;
    localparam logic [2:0] S_TICK_SEND = 3'd5;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_evt_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.func)
                    FUNC_PRESS: begin
                        o_cmd.do_press = 1'b1;
                        n_state        = S_IDLE;
                    end
                    FUNC_RELEASE: begin
                        o_cmd.do_release = 1'b1;
                        n_state          = S_IDLE;
                    end
                    FUNC_DRAG: begin
                        if (i_sts.is_pressed) begin
                            o_cmd.do_dist = 1'b1;
                            n_state       = S_DRAG_MUL;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    FUNC_TICK: begin
                        o_cmd.do_count = 1'b1;
                        n_state        = S_TICK_HOLD;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DRAG_MUL: begin
                o_cmd.do_mul = 1'b1;
                n_state      = S_DRAG_ACC;
            end
            S_DRAG_ACC: begin
                o_cmd.do_acc = 1'b1;
                n_state      = S_IDLE;
            end
            S_TICK_HOLD: begin
                o_cmd.do_hold = 1'b1;
                n_state       = S_TICK_SEND;
            end
            S_TICK_SEND: begin
                if (!i_sts.pending || !i_sts.host_ready) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.do_send = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_evt_ready = (r_state == S_IDLE);

    `TGM_ASSERT_NEXT(a_accept_exec, i_evt_valid && o_evt_ready, r_state == S_EXEC, "no decode after transfer")
    `TGM_ASSERT_NOW(a_send_free, o_cmd.do_send, i_sts.out_free, "report overwritten")
    `TGM_ASSERT_NEXT(a_send_wait, r_state == S_TICK_SEND && i_sts.pending && i_sts.host_ready && !i_sts.out_free, r_state == S_TICK_SEND, "report dropped")

endmodule

/* design/touch_gesture_to_hid_mouse.sv */
// Top level of the touch gesture to relative mouse report converter.
//
//   channel   dir  handshake          payload
//   i_evt     in   valid / ready      func, touch_x, touch_y, prev_x, prev_y, host_ready
//   o_rpt     out  valid / ready      left_button, move_x, move_y, wheel
//   i_cfg_*   in   write enable only  i_cfg_idx selects register, i_cfg_data value
//
// Press, release and an ignored drag go through transfer and decode; a drag goes through
// transfer, decode with distance and gain, multiply and accumulate, and a tick through transfer,
// decode and count, hold check and report; one event is in work at a time, the sequencer
// in tgm_ctrl sets these steps.
// A tick that sends a report waits while the report register still holds an earlier
// report that the host side has not taken; other events never wait on o_rpt.
// The report register lets the next event transfer in while a report is pending.
// Synchronous reset restores configuration, gesture state, queues and report valid;
// event latches and report payload are loaded before use. No clearing pass.
module touch_gesture_to_hid_mouse import tgm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tgm_evt_if.sink               i_evt,
    tgm_rpt_if.source             o_rpt,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    // Hold configuration; to be written only while the block is idle, which the block itself does not enforce.
    tgm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Advance one event through its steps; accept a transfer only when idle.
    tgm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (i_evt.valid),
        .o_evt_ready (i_evt.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Keep gesture state, movement queues and the outgoing report.
    tgm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_func        (i_evt.func),
        .i_touch_x     (i_evt.touch_x),
        .i_touch_y     (i_evt.touch_y),
        .i_prev_x      (i_evt.prev_x),
        .i_prev_y      (i_evt.prev_y),
        .i_host_ready  (i_evt.host_ready),
        .i_rpt_ready   (o_rpt.ready),
        .o_rpt_valid   (o_rpt.valid),
        .o_left_button (o_rpt.left_button),
        .o_move_x      (o_rpt.move_x),
        .o_move_y      (o_rpt.move_y),
        .o_wheel       (o_rpt.wheel)
    );

endmodule
